FILE: src/abpp_pkg.sv
// package for the alpha blend pixel packer
// payload structs, config struct, register codes and channel arithmetic
// no dependencies
`timescale 1ns / 1ps
package abpp_pkg;

    typedef struct packed {
        logic [7:0]  src_red;
        logic [7:0]  src_green;
        logic [7:0]  src_blue;
        logic [7:0]  src_alpha;
        logic [31:0] background_word;
        logic [15:0] screen_column;
        logic [15:0] screen_row;
        logic        last_in;
    } t_pixel_in;

    typedef struct packed {
        logic        write_enable;
        logic [31:0] pixel_value;
        logic        last_out;
    } t_pixel_out;

    typedef struct packed {
        logic [4:0]  red_size;
        logic [4:0]  red_position;
        logic [4:0]  green_size;
        logic [4:0]  green_position;
        logic [4:0]  blue_size;
        logic [4:0]  blue_position;
        logic [15:0] screen_width;
        logic [15:0] screen_height;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_RED_SIZE,
        REG_RED_POSITION,
        REG_GREEN_SIZE,
        REG_GREEN_POSITION,
        REG_BLUE_SIZE,
        REG_BLUE_POSITION,
        REG_SCREEN_WIDTH,
        REG_SCREEN_HEIGHT
    } t_reg_e;

    localparam logic [7:0] ALPHA_MIN    = 8'd16;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd254;
    localparam logic [7:0] ALPHA_FULL   = 8'd255;
    localparam logic [4:0] BYTE_BITS    = 5'd8;

    // exact x/255 for x below 65280
    function automatic logic [7:0] div255(input logic [16:0] x);
        logic [17:0] t;
        t = {1'b0, x} + 18'(x >> 8) + 18'd1;
        return t[15:8];
    endfunction

    // small sizes multiply (reciprocal at 3, 5-7 bits); exact over field range
    function automatic logic [7:0] expand_field(input logic [31:0] word,
                                                input logic [4:0]  n,
                                                input logic [4:0]  pos);
        logic [31:0] mask;
        logic [31:0] e;
        logic [15:0] e16;
        logic [7:0]  r;
        mask = (32'd1 << n) - 32'd1;
        e    = (word >> pos) & mask;
        e16  = {9'd0, e[6:0]};
        if (n >= BYTE_BITS) begin
            r = 8'(e >> (n - BYTE_BITS));
        end else begin
            case (n)
                5'd1:    r = 8'(e16 * 16'd255);
                5'd2:    r = 8'(e16 * 16'd85);
                5'd3:    r = 8'((32'(e16 * 16'd255 + 16'd3) * 32'd2341) >> 14);
                5'd4:    r = 8'(e16 * 16'd17);
                5'd5:    r = 8'((32'(e16 * 16'd255 + 16'd15) * 32'd8457) >> 18);
                5'd6:    r = 8'((32'(e16 * 16'd255 + 16'd31) * 32'd16645) >> 20);
                5'd7:    r = 8'((32'(e16 * 16'd255 + 16'd63) * 32'd33027) >> 22);
                default: r = 8'd0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [31:0] place_field(input logic [7:0] v,
                                                input logic [4:0] n,
                                                input logic [4:0] pos);
        logic [7:0]  m;
        logic [15:0] p;
        logic [31:0] f;
        m = (8'd1 << n[2:0]) - 8'd1;
        p = 16'(v) * 16'(m) + 16'd127;
        if (n >= BYTE_BITS) begin
            f = {24'd0, v} << (n - BYTE_BITS);
        end else if (n == 5'd0) begin
            f = 32'd0;
        end else begin
            f = {24'd0, div255({1'b0, p})};
        end
        return f << pos;
    endfunction

endpackage

FILE: src/alpha_blend_pixel_packer.sv
// top level of the alpha blend pixel packer: four stage blend pipeline
// depends on abpp_pkg and abpp_cfg
`timescale 1ns / 1ps
// One pixel enters per clock unless the output stalls; it passes the four
// pipeline stages (unpack and clip, multiply, divide by 255, pack).
// The whole pipeline advances together whenever the output register is
// empty or its result is being taken, so an output stall holds every stage.
// The user must write configuration through the apb port only while no
// pixel is in flight; the block itself does not enforce this.
module alpha_blend_pixel_packer import abpp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_pixel_in   i_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output t_pixel_out  o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg w_cfg;
    logic w_adv;

    abpp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic        r_v1, r_v2, r_v3, r_v4;
    logic [7:0]  r1_src [3];
    logic [7:0]  r1_bg  [3];
    logic [7:0]  r1_a;
    logic        r1_we, r1_last;
    logic [16:0] r2_prod [3];
    logic [7:0]  r2_src  [3];
    logic        r2_opaque, r2_we, r2_last;
    logic [7:0]  r3_ch [3];
    logic        r3_we, r3_last;
    t_pixel_out  r4_out;

    assign w_adv    = !r_v4 || !i_stall;
    assign o_stall  = !w_adv;
    assign o_valid  = r_v4;
    assign o_result = r4_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // unpack and clip
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_src[0] <= i_pixel.src_red;
            r1_src[1] <= i_pixel.src_green;
            r1_src[2] <= i_pixel.src_blue;
            r1_a      <= i_pixel.src_alpha;
            r1_bg[0]  <= expand_field(i_pixel.background_word, w_cfg.red_size,
                                      w_cfg.red_position);
            r1_bg[1]  <= expand_field(i_pixel.background_word, w_cfg.green_size,
                                      w_cfg.green_position);
            r1_bg[2]  <= expand_field(i_pixel.background_word, w_cfg.blue_size,
                                      w_cfg.blue_position);
            r1_we     <= (i_pixel.screen_column < w_cfg.screen_width)
                      && (i_pixel.screen_row < w_cfg.screen_height)
                      && (i_pixel.src_alpha >= ALPHA_MIN);
            r1_last   <= i_pixel.last_in;
        end
    end

    // weighted sum
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r2_prod[i] <= 17'(16'(r1_src[i]) * 16'(r1_a))
                            + 17'(16'(r1_bg[i]) * 16'(ALPHA_FULL - r1_a));
                r2_src[i]  <= r1_src[i];
            end
            r2_opaque <= r1_a >= ALPHA_OPAQUE;
            r2_we     <= r1_we;
            r2_last   <= r1_last;
        end
    end

    // divide and select
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r3_ch[i] <= r2_opaque ? r2_src[i] : div255(r2_prod[i]);
            end
            r3_we   <= r2_we;
            r3_last <= r2_last;
        end
    end

    // pack
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_out.write_enable <= r3_we;
            r4_out.pixel_value  <= r3_we ?
                (place_field(r3_ch[0], w_cfg.red_size, w_cfg.red_position)
               | place_field(r3_ch[1], w_cfg.green_size, w_cfg.green_position)
               | place_field(r3_ch[2], w_cfg.blue_size, w_cfg.blue_position))
                : 32'd0;
            r4_out.last_out     <= r3_last;
        end
    end

    a_skip_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.write_enable) |-> (o_result.pixel_value == 32'd0))
        else $error("skipped pixel carries a nonzero word");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input taken while output is held");

    a_flow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && w_adv) |=> o_valid)
        else $error("pixel lost leaving the divide stage");

endmodule

FILE: src/abpp_cfg.sv
// apb configuration registers of the alpha blend pixel packer
// depends on abpp_pkg
`timescale 1ns / 1ps
module abpp_cfg import abpp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg   r_cfg;
    t_cfg   n_cfg;
    t_reg_e w_idx;
    logic   w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_e'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_RED_SIZE:       n_cfg.red_size       = pwdata[4:0];
                REG_RED_POSITION:   n_cfg.red_position   = pwdata[4:0];
                REG_GREEN_SIZE:     n_cfg.green_size     = pwdata[4:0];
                REG_GREEN_POSITION: n_cfg.green_position = pwdata[4:0];
                REG_BLUE_SIZE:      n_cfg.blue_size      = pwdata[4:0];
                REG_BLUE_POSITION:  n_cfg.blue_position  = pwdata[4:0];
                REG_SCREEN_WIDTH:   n_cfg.screen_width   = pwdata[15:0];
                REG_SCREEN_HEIGHT:  n_cfg.screen_height  = pwdata[15:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_RED_SIZE:       prdata = {27'd0, r_cfg.red_size};
            REG_RED_POSITION:   prdata = {27'd0, r_cfg.red_position};
            REG_GREEN_SIZE:     prdata = {27'd0, r_cfg.green_size};
            REG_GREEN_POSITION: prdata = {27'd0, r_cfg.green_position};
            REG_BLUE_SIZE:      prdata = {27'd0, r_cfg.blue_size};
            REG_BLUE_POSITION:  prdata = {27'd0, r_cfg.blue_position};
            REG_SCREEN_WIDTH:   prdata = {16'd0, r_cfg.screen_width};
            REG_SCREEN_HEIGHT:  prdata = {16'd0, r_cfg.screen_height};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_size       <= 5'd8;
            r_cfg.red_position   <= 5'd16;
            r_cfg.green_size     <= 5'd8;
            r_cfg.green_position <= 5'd8;
            r_cfg.blue_size      <= 5'd8;
            r_cfg.blue_position  <= 5'd0;
            r_cfg.screen_width   <= 16'd1024;
            r_cfg.screen_height  <= 16'd768;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: bench/tb_alpha_blend_pixel_packer.sv
// self-checking bench for alpha_blend_pixel_packer: directed table, then random pixels
// predicts blend results or takes them from the table, compares transfers; depends on abpp_pkg
`timescale 1ns / 1ps
module tb_alpha_blend_pixel_packer import abpp_pkg::*;;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_pixel_in   i_pixel;
    logic        o_valid;
    logic        i_stall;
    t_pixel_out  o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    alpha_blend_pixel_packer dut (.*);

    typedef struct {
        t_pixel_in  pix;
        logic       known;
        t_pixel_out res;
    } t_row;

    t_cfg       fb_cfg;
    t_pixel_out blend_q[$];
    int         errors;
    int         sent;
    int         hold_len;
    bit         quiet_out;
    bit         quiet_in;
    t_row       rows[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("tb_alpha_blend_pixel_packer: done, errors");
        $finish;
    end

    function automatic logic [31:0] chan_to_field(logic [7:0] v, logic [4:0] n,
                                                  logic [4:0] pos);
        logic [63:0] f;
        logic [31:0] m;
        if (n >= 5'd8) f = 64'(v) << (n - 5'd8);
        else if (n == 5'd0) f = 64'd0;
        else begin
            m = (32'd1 << n) - 32'd1;
            f = 64'((32'(v) * m + 32'd127) / 32'd255);
        end
        f = f << pos;
        return f[31:0];
    endfunction

    function automatic logic [7:0] field_to_chan(logic [31:0] w, logic [4:0] n,
                                                 logic [4:0] pos);
        logic [63:0] m;
        logic [63:0] e;
        m = (64'd1 << n) - 64'd1;
        e = (64'(w) >> pos) & m;
        if (n >= 5'd8) return 8'(e >> (n - 5'd8));
        if (n == 5'd0) return 8'd0;
        return 8'((e * 64'd255 + m / 64'd2) / m);
    endfunction

    function automatic logic [7:0] mix_chan(logic [7:0] s, logic [7:0] b, logic [7:0] a);
        return 8'((32'(s) * 32'(a) + 32'(b) * (32'd255 - 32'(a))) / 32'd255);
    endfunction

    function automatic logic [31:0] pack_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        return chan_to_field(r, fb_cfg.red_size, fb_cfg.red_position)
             | chan_to_field(g, fb_cfg.green_size, fb_cfg.green_position)
             | chan_to_field(b, fb_cfg.blue_size, fb_cfg.blue_position);
    endfunction

    function automatic t_pixel_out blend_pixel(t_pixel_in p);
        t_pixel_out o;
        logic [7:0] er, eg, eb;
        o = '0;
        o.last_out = p.last_in;
        if (p.screen_column < fb_cfg.screen_width && p.screen_row < fb_cfg.screen_height
                && p.src_alpha >= ALPHA_MIN) begin
            o.write_enable = 1'b1;
            if (p.src_alpha >= ALPHA_OPAQUE) begin
                o.pixel_value = pack_rgb(p.src_red, p.src_green, p.src_blue);
            end else begin
                er = field_to_chan(p.background_word, fb_cfg.red_size, fb_cfg.red_position);
                eg = field_to_chan(p.background_word, fb_cfg.green_size,
                                   fb_cfg.green_position);
                eb = field_to_chan(p.background_word, fb_cfg.blue_size, fb_cfg.blue_position);
                o.pixel_value = pack_rgb(mix_chan(p.src_red, er, p.src_alpha),
                                         mix_chan(p.src_green, eg, p.src_alpha),
                                         mix_chan(p.src_blue, eb, p.src_alpha));
            end
        end
        return o;
    endfunction

    task automatic write_reg(t_reg_e idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RED_SIZE:       fb_cfg.red_size       = val[4:0];
            REG_RED_POSITION:   fb_cfg.red_position   = val[4:0];
            REG_GREEN_SIZE:     fb_cfg.green_size     = val[4:0];
            REG_GREEN_POSITION: fb_cfg.green_position = val[4:0];
            REG_BLUE_SIZE:      fb_cfg.blue_size      = val[4:0];
            REG_BLUE_POSITION:  fb_cfg.blue_position  = val[4:0];
            REG_SCREEN_WIDTH:   fb_cfg.screen_width   = val[15:0];
            default:            fb_cfg.screen_height  = val[15:0];
        endcase
    endtask

    task automatic write_layout(int rs, int rp, int gs, int gp, int bs, int bp,
                                int w, int h);
        write_reg(REG_RED_SIZE, rs);
        write_reg(REG_RED_POSITION, rp);
        write_reg(REG_GREEN_SIZE, gs);
        write_reg(REG_GREEN_POSITION, gp);
        write_reg(REG_BLUE_SIZE, bs);
        write_reg(REG_BLUE_POSITION, bp);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
    endtask

    // valid stays high across back to back transfers, except for random idle gaps unless quiet_in
    task automatic send_pixel(t_pixel_in p, t_pixel_out expd);
        @(negedge i_clk);
        while (!quiet_in && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            i_pixel <= '0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= p;
        blend_q.push_back(expd);
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        i_pixel <= '0;
        while (blend_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic t_pixel_in rand_pixel(int mode);
        t_pixel_in p;
        p.src_red   = 8'($urandom);
        p.src_green = 8'($urandom);
        p.src_blue  = 8'($urandom);
        case ($urandom_range(5))
            0:       p.src_alpha = 8'($urandom_range(15));
            1:       p.src_alpha = 8'($urandom_range(255, 254));
            default: p.src_alpha = 8'($urandom);
        endcase
        p.background_word = $urandom;
        if (mode == 0 || $urandom_range(9) == 0) begin
            p.screen_column = 16'($urandom);
            p.screen_row    = 16'($urandom);
        end else begin
            p.screen_column = 16'($urandom_range(fb_cfg.screen_width + 1));
            p.screen_row    = 16'($urandom_range(fb_cfg.screen_height + 1));
        end
        p.last_in = 1'($urandom);
        return p;
    endfunction

    function automatic t_row mk_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                    logic [7:0] a, logic [31:0] bg, logic [15:0] x,
                                    logic [15:0] y, logic l, logic known,
                                    logic we, logic [31:0] pv);
        t_row t;
        t.pix   = '{r, g, b, a, bg, x, y, l};
        t.known = known;
        t.res   = '{we, pv, l};
        return t;
    endfunction

    // output side: random stall, one long hold-off, checks every transfer
    initial begin
        t_pixel_out expd;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                i_stall <= 1'b1;
                hold_len--;
            end else begin
                i_stall <= !quiet_out && $urandom_range(99) < 6;
            end
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                if (blend_q.size() == 0) begin
                    $error("result with nothing expected: %p", o_result);
                    errors++;
                end else begin
                    expd = blend_q.pop_front();
                    if (o_result.write_enable !== expd.write_enable) begin
                        $error("write_enable exp %0b got %0b", expd.write_enable,
                               o_result.write_enable);
                        errors++;
                    end
                    if (o_result.pixel_value !== expd.pixel_value) begin
                        $error("pixel_value exp %h got %h", expd.pixel_value,
                               o_result.pixel_value);
                        errors++;
                    end
                    if (o_result.last_out !== expd.last_out) begin
                        $error("last_out exp %0b got %0b", expd.last_out, o_result.last_out);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        t_pixel_out expd;
        int phase;
        errors = 0;
        sent = 0;
        hold_len = 0;
        quiet_out = 1'b0;
        quiet_in = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pixel = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fb_cfg = '{5'd8, 5'd16, 5'd8, 5'd8, 5'd8, 5'd0, 16'd1024, 16'd768};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset layout, extremes and special cases
        rows.push_back(mk_row(8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 1, 1, 32'h00ffffff));
        rows.push_back(mk_row(8'h12, 8'h34, 8'h56, 8'hfe, 0, 1023, 767, 1, 1, 1,
                              32'h00123456));
        rows.push_back(mk_row(8'hff, 8'hff, 8'hff, 8'hff, 0, 1024, 0, 0, 1, 0, 0));
        rows.push_back(mk_row(8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 768, 1, 1, 0, 0));
        rows.push_back(mk_row(8'hff, 8'hff, 8'hff, 8'h0f, 0, 5, 5, 0, 1, 0, 0));
        rows.push_back(mk_row(8'hff, 8'hff, 8'hff, 8'hff, 0, 16'hffff, 16'hffff, 1, 1, 0, 0));
        rows.push_back(mk_row(0, 0, 0, 8'h10, 32'hffffffff, 3, 3, 0, 0, 0, 0));
        rows.push_back(mk_row(8'hff, 0, 8'h80, 8'h80, 32'h00a5c3e1, 7, 9, 1, 0, 0, 0));
        rows.push_back(mk_row(8'h40, 8'hc0, 8'h20, 8'hfd, 32'hffffffff, 1, 1, 0, 0, 0, 0));
        foreach (rows[i]) begin
            expd = blend_pixel(rows[i].pix);
            if (rows[i].known) expd = rows[i].res;
            send_pixel(rows[i].pix, expd);
        end
        drain();

        // zero sizes and tiny screen
        write_layout(0, 31, 0, 0, 0, 0, 1, 1);
        rows = {};
        rows.push_back(mk_row(8'hff, 8'hff, 8'hff, 8'hff, 32'hffffffff, 0, 0, 1, 1, 1, 0));
        rows.push_back(mk_row(8'hff, 8'hff, 8'hff, 8'hff, 0, 1, 0, 0, 1, 0, 0));
        rows.push_back(mk_row(8'h55, 8'h66, 8'h77, 8'h20, 32'h12345678, 0, 0, 0, 0, 0, 0));
        foreach (rows[i]) begin
            expd = blend_pixel(rows[i].pix);
            if (rows[i].known) expd = rows[i].res;
            send_pixel(rows[i].pix, expd);
        end
        drain();

        for (phase = 0; phase < 10; phase++) begin
            case (phase)
                0: write_layout(5, 11, 6, 5, 5, 0, 640, 480);
                1: write_layout(16, 16, 16, 0, 1, 31, 65535, 65535);
                2: write_layout(31, 31, 31, 31, 31, 31, 100, 100);
                3: write_layout(7, 25, 3, 1, 2, 14, 1, 65535);
                4: write_layout(4, 28, 4, 24, 4, 20, 320, 200);
                default: write_layout($urandom_range(16), $urandom_range(31),
                                      $urandom_range(16), $urandom_range(31),
                                      $urandom_range(16), $urandom_range(31),
                                      $urandom_range(65535, 1), $urandom_range(65535, 1));
            endcase
            quiet_in = (phase == 3);
            quiet_out = (phase == 3);
            if (phase == 6) hold_len = 200;
            repeat (95) begin
                t_pixel_in p;
                p = rand_pixel(phase == 2 ? 0 : 1);
                send_pixel(p, blend_pixel(p));
            end
            drain();
        end

        quiet_in = 1'b0;
        quiet_out = 1'b0;
        if (errors == 0) begin
            $display("tb_alpha_blend_pixel_packer: done, clean");
        end else begin
            $display("tb_alpha_blend_pixel_packer: done, errors");
        end
        $finish;
    end

endmodule
